// ===== hw/rtl/ilha_pkg.sv =====
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types and codes of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

    localparam int FIRST_PAYLOAD = 32;
    localparam int MIN_BLOCK     = 32;
    localparam int SMALL_REQUEST = 16;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NULL      = 3'd1;
    localparam status_t ST_RANGE     = 3'd2;
    localparam status_t ST_ALIGN     = 3'd3;
    localparam status_t ST_NOT_ALLOC = 3'd4;
    localparam status_t ST_NO_MEM    = 3'd5;
    localparam status_t ST_ZERO      = 3'd6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_bytes;
        logic [15:0] block_address;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] payload_address;
        status_t     status;
        logic [16:0] granted_bytes;
    } res_word_t;

    typedef enum logic [5:0] {
        S_CLEAR,
        S_IDLE,
        S_FF_RD,
        S_FF_CHK,
        S_GROW,
        S_GROW_F,
        S_GROW_E,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_MPA_W1,
        S_MPA_RD,
        S_MPA_W2,
        S_MNA_W1,
        S_MNA_RD,
        S_MNA_W2,
        S_MNN_W1,
        S_MNN_RD1,
        S_MNN_RD2,
        S_MNN_W2,
        S_MNN_RD3,
        S_MNN_SET,
        S_M_END,
        S_P_RD,
        S_P_CHK,
        S_P_W_F,
        S_P_W_NH,
        S_P_RD_NH,
        S_P_W_NF,
        S_F_RD,
        S_F_CHK,
        S_F_W_F,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/ilha_tag_ram.sv =====
// ----------------------------------------------------------------------------
// ilha_tag_ram
// Single-port-write, single-port-read tag store with registered read data.
// ----------------------------------------------------------------------------
module ilha_tag_ram #(
    parameter int DEPTH = 8192,
    parameter int IW    = 13,
    parameter int DW    = 17
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [DW-1:0] wr_data,
    input  logic [IW-1:0] rd_idx,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_idx];
    end

endmodule

// ===== hw/rtl/implicit_list_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator
// First-fit boundary-tag heap allocator over an implicit block list.
// ----------------------------------------------------------------------------
// All header and footer tags live in one synchronous tag RAM of HEAP_BYTES/8
// words. Every tag access is a RAM read or write, and a sequencer issues
// them in order. After reset a clearing pass over all HEAP_BYTES/8 words
// lays down the initial heap image, and commands are stalled until it ends.
// What each command does:
// - A command rejected by the size or address checks touches no tag.
// - A release of a block that is not allocated reads its header and stops.
// - A good release frees the block and merges it with any free neighbors.
// - An allocate walks the blocks in a first-fit search, then places the
//   block, splitting it when the rest would be at least MIN_BLOCK bytes.
// - When the walk finds no fit, the allocate ends the walk, grows the
//   break and merges, then places the block.
// One command is worked at a time. A finished result waits in an output
// register while the next command is taken.
module implicit_list_heap_allocator #(
    parameter int HEAP_BYTES  = 65536,
    parameter int CHUNK_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  ilha_pkg::cmd_word_t  cmd_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output ilha_pkg::res_word_t  res_word
);

    import ilha_pkg::*;

    localparam int AW        = $clog2(HEAP_BYTES) + 1;
    localparam int TW        = AW;
    localparam int XW        = ((AW > 16) ? AW : 16) + 4;
    localparam int TAG_WORDS = HEAP_BYTES / 8;
    localparam int IW        = $clog2(TAG_WORDS);

    localparam int INIT_WORDS = CHUNK_BYTES / 8;
    localparam int INIT_SZ    = (INIT_WORDS + (INIT_WORDS % 2)) * 8;
    localparam bit INIT_FITS  = (FIRST_PAYLOAD + INIT_SZ) <= HEAP_BYTES;
    localparam int INIT_BRK   = INIT_FITS ? (FIRST_PAYLOAD + INIT_SZ) : FIRST_PAYLOAD;
    localparam int IDX_FTR    = (16 + INIT_SZ) / 8;
    localparam int IDX_EPI    = (24 + INIT_SZ) / 8;

    localparam logic [XW-1:0] X8     = XW'(8);
    localparam logic [XW-1:0] X16    = XW'(16);
    localparam logic [XW-1:0] X31    = XW'(31);
    localparam logic [XW-1:0] XMIN   = XW'(MIN_BLOCK);
    localparam logic [XW-1:0] XFIRST = XW'(FIRST_PAYLOAD);
    localparam logic [XW-1:0] XCHUNK = XW'(CHUNK_BYTES);
    localparam logic [XW-1:0] XHEAP  = XW'(HEAP_BYTES);
    localparam logic [XW-1:0] XWORDS = XW'(TAG_WORDS);

    state_t state_reg, state_next;

    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [AW-1:0] brk_reg, brk_next;
    logic [XW-1:0] bp_reg, bp_next;
    logic [XW-1:0] p_reg, p_next;
    logic [XW-1:0] pb_reg, pb_next;
    logic [XW-1:0] n_reg, n_next;
    logic [XW-1:0] bsz_reg, bsz_next;
    logic [XW-1:0] dsz_reg, dsz_next;
    logic [XW-1:0] sz_reg, sz_next;
    logic [XW-1:0] asize_reg, asize_next;
    logic [XW-1:0] gsz_reg, gsz_next;
    logic          pa_reg, pa_next;
    logic          split_reg, split_next;
    logic          is_free_reg, is_free_next;
    res_word_t     res_reg, res_next;
    logic          res_valid_reg, res_valid_next;
    res_word_t     res_word_reg, res_word_next;
    logic          rd_ok_reg;

    logic [XW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [TW-1:0] wr_data;
    logic [TW-1:0] rd_data;
    logic          wr_ok, rd_ok;

    logic [TW-1:0] rv;
    logic [XW-1:0] rsz;
    logic          ra;
    logic [XW-1:0] brk_x;
    logic [XW-1:0] req_x, addr_x;
    logic [XW-1:0] ext, grow_sz, p_rest;
    logic          acc, ff_more, ff_hit, grow_fail, p_split, res_free;
    logic          bad_range, bad_align;
    logic [TW-1:0] init_word;

    assign rv    = rd_ok_reg ? rd_data : '0;
    assign rsz   = XW'({rv[TW-1:3], 3'b000});
    assign ra    = rv[0];
    assign brk_x = XW'(brk_reg);
    assign req_x = XW'(cmd_word.request_bytes);
    assign addr_x = XW'(cmd_word.block_address);

    assign acc       = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign ff_more   = p_reg < brk_x;
    assign ff_hit    = !ra && (asize_reg <= rsz);
    assign ext       = (asize_reg > XCHUNK) ? asize_reg : XCHUNK;
    assign grow_sz   = ((ext >> 3) + XW'(ext[3])) << 3;
    assign grow_fail = (brk_x + grow_sz) > XHEAP;
    assign p_rest    = rsz - asize_reg;
    assign p_split   = p_rest >= XMIN;
    assign res_free  = !res_valid_reg || !res_stall;
    assign bad_range = (addr_x < XFIRST) || (addr_x >= brk_x);
    assign bad_align = (cmd_word.block_address[2:0] != 3'b000);

    assign wr_ok = (wr_addr >> 3) < XWORDS;
    assign rd_ok = (rd_addr >> 3) < XWORDS;

    always_comb
    begin
        init_word = '0;
        if ((clr_idx_reg == IW'(1)) || (clr_idx_reg == IW'(2)))
        begin
            init_word = TW'(17);
        end
        else if (clr_idx_reg == IW'(3))
        begin
            init_word = INIT_FITS ? TW'(INIT_SZ) : TW'(1);
        end
        else if (INIT_FITS && (clr_idx_reg == IW'(IDX_FTR)))
        begin
            init_word = TW'(INIT_SZ);
        end
        else if (INIT_FITS && (clr_idx_reg == IW'(IDX_EPI)))
        begin
            init_word = TW'(1);
        end
    end

    ilha_tag_ram #(
        .DEPTH (TAG_WORDS),
        .IW    (IW),
        .DW    (TW)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en && wr_ok),
        .wr_idx  (wr_addr[IW+2:3]),
        .wr_data (wr_data),
        .rd_idx  (rd_addr[IW+2:3]),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == IW'(TAG_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cmd_word.command == CMD_ALLOC)
                    begin
                        state_next = (cmd_word.request_bytes == 16'd0) ? S_DONE : S_FF_RD;
                    end
                    else if ((cmd_word.block_address == 16'd0) || bad_range || bad_align)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_FF_RD:   state_next = ff_more ? S_FF_CHK : S_GROW;
            S_FF_CHK:
            begin
                priority if (rsz == '0)
                begin
                    state_next = S_GROW;
                end
                else if (ff_hit)
                begin
                    state_next = S_P_RD;
                end
                else
                begin
                    state_next = S_FF_RD;
                end
            end
            S_GROW:    state_next = grow_fail ? S_DONE : S_GROW_F;
            S_GROW_F:  state_next = S_GROW_E;
            S_GROW_E:  state_next = S_M0;
            S_M0:      state_next = S_M1;
            S_M1:      state_next = S_M2;
            S_M2:      state_next = S_M3;
            S_M3:      state_next = S_M4;
            S_M4:      state_next = S_M5;
            S_M5:
            begin
                priority if (pa_reg && ra)
                begin
                    state_next = S_M_END;
                end
                else if (pa_reg)
                begin
                    state_next = S_MPA_W1;
                end
                else if (ra)
                begin
                    state_next = S_MNA_W1;
                end
                else
                begin
                    state_next = S_MNN_W1;
                end
            end
            S_MPA_W1:  state_next = S_MPA_RD;
            S_MPA_RD:  state_next = S_MPA_W2;
            S_MPA_W2:  state_next = S_M_END;
            S_MNA_W1:  state_next = S_MNA_RD;
            S_MNA_RD:  state_next = S_MNA_W2;
            S_MNA_W2:  state_next = S_M_END;
            S_MNN_W1:  state_next = S_MNN_RD1;
            S_MNN_RD1: state_next = S_MNN_RD2;
            S_MNN_RD2: state_next = S_MNN_W2;
            S_MNN_W2:  state_next = S_MNN_RD3;
            S_MNN_RD3: state_next = S_MNN_SET;
            S_MNN_SET: state_next = S_M_END;
            S_M_END:   state_next = is_free_reg ? S_DONE : S_P_RD;
            S_P_RD:    state_next = S_P_CHK;
            S_P_CHK:   state_next = S_P_W_F;
            S_P_W_F:   state_next = split_reg ? S_P_W_NH : S_DONE;
            S_P_W_NH:  state_next = S_P_RD_NH;
            S_P_RD_NH: state_next = S_P_W_NF;
            S_P_W_NF:  state_next = S_DONE;
            S_F_RD:    state_next = S_F_CHK;
            S_F_CHK:   state_next = ra ? S_F_W_F : S_DONE;
            S_F_W_F:   state_next = S_M0;
            S_DONE:    state_next = res_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // tag accesses and datapath
    always_comb
    begin
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        clr_idx_next   = clr_idx_reg;
        brk_next       = brk_reg;
        bp_next        = bp_reg;
        p_next         = p_reg;
        pb_next        = pb_reg;
        n_next         = n_reg;
        bsz_next       = bsz_reg;
        dsz_next       = dsz_reg;
        sz_next        = sz_reg;
        asize_next     = asize_reg;
        gsz_next       = gsz_reg;
        pa_next        = pa_reg;
        split_next     = split_reg;
        is_free_next   = is_free_reg;
        res_next       = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = XW'({clr_idx_reg, 3'b000});
                wr_data      = init_word;
                clr_idx_next = clr_idx_reg + IW'(1);
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    bp_next    = addr_x;
                    p_next     = XFIRST;
                    asize_next = (req_x <= X16) ? XMIN : ((req_x + X31) & ~XW'(15));
                    res_next   = '{payload_address: 16'd0, status: ST_OK,
                                   granted_bytes: 17'd0};
                    if (cmd_word.command == CMD_ALLOC)
                    begin
                        if (cmd_word.request_bytes == 16'd0)
                        begin
                            res_next.status = ST_ZERO;
                        end
                    end
                    else
                    begin
                        priority if (cmd_word.block_address == 16'd0)
                        begin
                            res_next.status = ST_NULL;
                        end
                        else if (bad_range)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else if (bad_align)
                        begin
                            res_next.status = ST_ALIGN;
                        end
                        else
                        begin
                            res_next.status = ST_OK;
                        end
                    end
                end
            end
            S_FF_RD:
            begin
                rd_addr = p_reg - X8;
            end
            S_FF_CHK:
            begin
                if ((rsz != '0) && ff_hit)
                begin
                    bp_next = p_reg;
                end
                p_next = p_reg + rsz;
            end
            S_GROW:
            begin
                if (grow_fail)
                begin
                    res_next.status = ST_NO_MEM;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = brk_x - X8;
                    wr_data  = grow_sz[TW-1:0];
                    bp_next  = brk_x;
                    brk_next = brk_reg + grow_sz[AW-1:0];
                    sz_next  = grow_sz;
                end
            end
            S_GROW_F:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + sz_reg - X16;
                wr_data = sz_reg[TW-1:0];
            end
            S_GROW_E:
            begin
                wr_en        = 1'b1;
                wr_addr      = bp_reg + sz_reg - X8;
                wr_data      = TW'(1);
                is_free_next = 1'b0;
            end
            S_M0:
            begin
                rd_addr = bp_reg - X16;
            end
            S_M1:
            begin
                pb_next = bp_reg - rsz;
                rd_addr = bp_reg - rsz - X8;
            end
            S_M2:
            begin
                bsz_next = rsz;
                rd_addr  = pb_reg + rsz - X16;
            end
            S_M3:
            begin
                pa_next = ra;
                rd_addr = bp_reg - X8;
            end
            S_M4:
            begin
                dsz_next = rsz;
                n_next   = bp_reg + rsz;
                rd_addr  = bp_reg + rsz - X8;
            end
            S_M5:
            begin
                // fetch the next block's footer for the merge on both sides
                rd_addr = n_reg + rsz - X16;
                sz_next = pa_reg ? (dsz_reg + rsz) : (dsz_reg + bsz_reg);
            end
            S_MPA_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg - X8;
                wr_data = sz_reg[TW-1:0];
            end
            S_MPA_RD:
            begin
                rd_addr = bp_reg - X8;
            end
            S_MPA_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + rsz - X16;
                wr_data = sz_reg[TW-1:0];
            end
            S_MNA_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + dsz_reg - X16;
                wr_data = sz_reg[TW-1:0];
            end
            S_MNA_RD:
            begin
                rd_addr = bp_reg - X16;
            end
            S_MNA_W2:
            begin
                bp_next = bp_reg - rsz;
                wr_en   = 1'b1;
                wr_addr = bp_reg - rsz - X8;
                wr_data = sz_reg[TW-1:0];
            end
            S_MNN_W1:
            begin
                sz_next = dsz_reg + bsz_reg + rsz;
                wr_en   = 1'b1;
                wr_addr = pb_reg - X8;
                wr_data = sz_next[TW-1:0];
            end
            S_MNN_RD1:
            begin
                rd_addr = bp_reg - X8;
            end
            S_MNN_RD2:
            begin
                n_next  = bp_reg + rsz;
                rd_addr = bp_reg + rsz - X8;
            end
            S_MNN_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = n_reg + rsz - X16;
                wr_data = sz_reg[TW-1:0];
            end
            S_MNN_RD3:
            begin
                rd_addr = bp_reg - X16;
            end
            S_MNN_SET:
            begin
                bp_next = bp_reg - rsz;
            end
            S_M_END:
            begin
                if (is_free_reg)
                begin
                    res_next = '{payload_address: 16'd0, status: ST_OK,
                                 granted_bytes: gsz_reg[16:0]};
                end
            end
            S_P_RD:
            begin
                rd_addr = bp_reg - X8;
            end
            S_P_CHK:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg - X8;
                if (p_split)
                begin
                    wr_data    = asize_reg[TW-1:0] | TW'(1);
                    gsz_next   = asize_reg;
                    sz_next    = p_rest;
                    split_next = 1'b1;
                end
                else
                begin
                    wr_data    = rsz[TW-1:0] | TW'(1);
                    gsz_next   = rsz;
                    split_next = 1'b0;
                end
            end
            S_P_W_F:
            begin
                wr_en    = 1'b1;
                wr_addr  = bp_reg + gsz_reg - X16;
                wr_data  = gsz_reg[TW-1:0] | TW'(1);
                res_next = '{payload_address: bp_reg[15:0], status: ST_OK,
                             granted_bytes: gsz_reg[16:0]};
            end
            S_P_W_NH:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + gsz_reg - X8;
                wr_data = sz_reg[TW-1:0];
            end
            S_P_RD_NH:
            begin
                rd_addr = bp_reg + gsz_reg - X8;
            end
            S_P_W_NF:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + gsz_reg + rsz - X16;
                wr_data = sz_reg[TW-1:0];
            end
            S_F_RD:
            begin
                rd_addr = bp_reg - X8;
            end
            S_F_CHK:
            begin
                if (!ra)
                begin
                    res_next.status = ST_NOT_ALLOC;
                end
                else
                begin
                    gsz_next = rsz;
                    sz_next  = rsz;
                    wr_en    = 1'b1;
                    wr_addr  = bp_reg - X8;
                    wr_data  = rsz[TW-1:0];
                end
            end
            S_F_W_F:
            begin
                wr_en        = 1'b1;
                wr_addr      = bp_reg + sz_reg - X16;
                wr_data      = sz_reg[TW-1:0];
                is_free_next = 1'b1;
            end
            S_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // output word register: load on finish, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        priority if ((state_reg == S_DONE) && res_free)
        begin
            res_valid_next = 1'b1;
            res_word_next  = res_reg;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            brk_reg       <= AW'(INIT_BRK);
            res_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            split_reg     <= 1'b0;
            is_free_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            brk_reg       <= brk_next;
            res_valid_reg <= res_valid_next;
            rd_ok_reg     <= rd_ok;
            split_reg     <= split_next;
            is_free_reg   <= is_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bp_reg       <= bp_next;
        p_reg        <= p_next;
        pb_reg       <= pb_next;
        n_reg        <= n_next;
        bsz_reg      <= bsz_next;
        dsz_reg      <= dsz_next;
        sz_reg       <= sz_next;
        asize_reg    <= asize_next;
        gsz_reg      <= gsz_next;
        pa_reg       <= pa_next;
        res_reg      <= res_next;
        res_word_reg <= res_word_next;
    end

    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(brk_reg) <= XHEAP) && (brk_reg[2:0] == 3'b000))
        else $error("break offset out of arena or misaligned");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_valid_reg && res_stall) |=> (state_reg == S_DONE))
        else $error("finished result left while output slot was full");

    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_word_reg.status != ST_OK)
            |-> (res_word_reg.granted_bytes == 17'd0 && res_word_reg.payload_address == 16'd0))
        else $error("failed command reports a grant");

    a_walk_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FF_RD) |-> (p_reg[2:0] == 3'b000))
        else $error("first-fit walk pointer misaligned");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("tag write outside a command");

endmodule
